FILE: hw/rtl/pbgsc_pkg.sv
// ---------------------------------------------------------------------------
// pbgsc_pkg
// Shared types and codes for the park buzzer gear/speed controller.
// ---------------------------------------------------------------------------
package pbgsc_pkg;

  localparam int SpeedW   = 12;
  localparam int WaitW    = 16;
  localparam int GearW    = 3;
  localparam int CmdW     = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_SWITCH_OFF_SPEED = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_WAIT_TICKS   = 1'd1;

  localparam logic [SpeedW-1:0] SWITCH_OFF_SPEED_RST = 12'd100;
  localparam logic [WaitW-1:0]  OFF_WAIT_TICKS_RST   = 16'd1000;

  // Item opcodes and frame kinds.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] KIND_SPEED = 2'd0;
  localparam logic [1:0] KIND_GEAR  = 2'd1;

  // Stored gear codes.
  localparam logic [GearW-1:0] GEAR_NONE = 3'd0;
  localparam logic [GearW-1:0] GEAR_P    = 3'd1;
  localparam logic [GearW-1:0] GEAR_R    = 3'd2;
  localparam logic [GearW-1:0] GEAR_N    = 3'd3;
  localparam logic [GearW-1:0] GEAR_D    = 3'd4;

  // Buzzer switch commands.
  localparam logic [CmdW-1:0] CMD_NONE = 2'd0;
  localparam logic [CmdW-1:0] CMD_ON   = 2'd1;
  localparam logic [CmdW-1:0] CMD_OFF  = 2'd2;

  // Payload bit masks of the gear nibble and the speed upper nibble.
  localparam logic [7:0] MASK_NIBBLE = 8'h0F;
  localparam logic [7:0] MASK_P      = 8'h01;
  localparam logic [7:0] MASK_R      = 8'h02;
  localparam logic [7:0] MASK_N      = 8'h04;
  localparam logic [7:0] MASK_D      = 8'h08;

  typedef enum logic [1:0] {
    BZ_ENABLED  = 2'b01,
    BZ_DISABLED = 2'b10
  } buzzer_state_t;

  typedef enum logic [3:0] {
    EV_NONE   = 4'b0001,
    EV_SPEED  = 4'b0010,
    EV_GEAR   = 4'b0100,
    EV_EXPIRY = 4'b1000
  } event_t;

endpackage

FILE: hw/rtl/pbgsc_if.sv
// ---------------------------------------------------------------------------
// pbgsc_in_if / pbgsc_out_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface pbgsc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] frame_kind;
  logic [7:0] byte0;
  logic [7:0] byte1;

  modport source (output valid, output op, output frame_kind, output byte0,
                  output byte1, input ready);
  modport sink   (input valid, input op, input frame_kind, input byte0,
                  input byte1, output ready);
endinterface

interface pbgsc_out_if;
  logic        valid;
  logic        ready;
  logic        buzzer_enabled;
  logic [1:0]  buzzer_cmd;
  logic        timer_running;
  logic [11:0] speed_seen;
  logic [2:0]  gear_seen;

  modport source (output valid, output buzzer_enabled, output buzzer_cmd,
                  output timer_running, output speed_seen, output gear_seen,
                  input ready);
  modport sink   (input valid, input buzzer_enabled, input buzzer_cmd,
                  input timer_running, input speed_seen, input gear_seen,
                  output ready);
endinterface

FILE: hw/rtl/park_buzzer_gear_speed_controller.sv
// ---------------------------------------------------------------------------
// park_buzzer_gear_speed_controller
// Parking buzzer enable logic driven by decoded speed/gear frames and ticks.
// ---------------------------------------------------------------------------
// A result word appears in the cycle after its input word is accepted.
// Throughput: one word per cycle unless the output stalls; state and result
// registers load at the accepting edge, so the next word sees the new state.
// Reset (rst, synchronous, active high): buzzer enabled, speed and gear
// unknown, countdown stopped, registers back to their defaults, no result.
// ---------------------------------------------------------------------------
module park_buzzer_gear_speed_controller import pbgsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  pbgsc_in_if.sink            in_ch,
  pbgsc_out_if.source         out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers.
  logic [SpeedW-1:0] switch_off_speed;
  logic [WaitW-1:0]  off_wait_ticks;

  // Controller state and its next values.
  buzzer_state_t     buzzer, buzzer_next;
  logic [SpeedW-1:0] stored_speed, stored_speed_next;
  logic              speed_known, speed_known_next;
  logic [GearW-1:0]  stored_gear, stored_gear_next;
  logic [WaitW-1:0]  countdown, countdown_next;
  logic              countdown_active, countdown_active_next;

  // Result register.
  logic              res_valid;
  logic              res_enabled;
  logic [CmdW-1:0]   res_cmd;
  logic              res_timer;
  logic [SpeedW-1:0] res_speed;
  logic [GearW-1:0]  res_gear;

  logic              accept;
  event_t            ev;
  logic [CmdW-1:0]   cmd;
  logic [SpeedW-1:0] frame_speed;
  logic [GearW-1:0]  frame_gear;
  logic              spd_zero, spd_high, spd_mid;

  // The result register acts as the output stage: a new word is taken
  // whenever it is empty or is being emptied in the same cycle.
  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign frame_speed = {in_ch.byte1[3:0] & MASK_NIBBLE[3:0], in_ch.byte0};

  // Lowest set bit of the gear nibble wins; an empty nibble means no gear.
  always_comb begin
    if ((in_ch.byte0 & MASK_P) != 8'd0) begin
      frame_gear = GEAR_P;
    end else if ((in_ch.byte0 & MASK_R) != 8'd0) begin
      frame_gear = GEAR_R;
    end else if ((in_ch.byte0 & MASK_N) != 8'd0) begin
      frame_gear = GEAR_N;
    end else if ((in_ch.byte0 & MASK_D) != 8'd0) begin
      frame_gear = GEAR_D;
    end else begin
      frame_gear = GEAR_NONE;
    end
  end

  // First stage of the step: store the new value and decide which event,
  // if any, this word raises. A value fires only when it changes, and the
  // first speed ever seen always fires.
  always_comb begin
    stored_speed_next = stored_speed;
    speed_known_next  = speed_known;
    stored_gear_next  = stored_gear;
    ev                = EV_NONE;
    if (in_ch.op == OP_TICK) begin
      if (countdown_active && countdown <= WaitW'(1)) begin
        ev = EV_EXPIRY;
      end
    end else if (in_ch.frame_kind == KIND_SPEED) begin
      if (!speed_known || frame_speed != stored_speed) begin
        stored_speed_next = frame_speed;
        speed_known_next  = 1'b1;
        ev                = EV_SPEED;
      end
    end else if (in_ch.frame_kind == KIND_GEAR) begin
      if (frame_gear != GEAR_NONE && frame_gear != stored_gear) begin
        stored_gear_next = frame_gear;
        ev               = EV_GEAR;
      end
    end
  end

  // Speed tests see the updated speed. With no speed known they are all false.
  assign spd_zero = speed_known_next && stored_speed_next == '0;
  assign spd_high = speed_known_next && stored_speed_next >= switch_off_speed;
  assign spd_mid  = speed_known_next && stored_speed_next != '0 &&
                    stored_speed_next < switch_off_speed;

  // Buzzer machine and countdown.
  always_comb begin
    buzzer_next           = buzzer;
    countdown_next        = countdown;
    countdown_active_next = countdown_active;
    cmd                   = CMD_NONE;

    // A tick only counts down a running timer; expiry clears it.
    if (in_ch.op == OP_TICK && countdown_active) begin
      if (countdown <= WaitW'(1)) begin
        countdown_next        = '0;
        countdown_active_next = 1'b0;
      end else begin
        countdown_next = countdown - WaitW'(1);
      end
    end

    case (buzzer)
      BZ_ENABLED: begin
        case (ev)
          EV_SPEED: begin
            // Reverse keeps the buzzer as it is.
            if (stored_gear_next != GEAR_R) begin
              if (spd_zero) begin
                countdown_next        = off_wait_ticks;
                countdown_active_next = 1'b1;
              end else begin
                countdown_active_next = 1'b0;
                if (spd_high) begin
                  cmd         = CMD_OFF;
                  buzzer_next = BZ_DISABLED;
                end
              end
            end
          end
          EV_GEAR: begin
            if (stored_gear_next == GEAR_P) begin
              cmd                   = CMD_OFF;
              countdown_active_next = 1'b0;
              buzzer_next           = BZ_DISABLED;
            end else if (stored_gear_next == GEAR_R) begin
              countdown_active_next = 1'b0;
            end else if (stored_gear_next == GEAR_N) begin
              if (spd_zero || spd_high) begin
                cmd                   = CMD_OFF;
                countdown_active_next = 1'b0;
                buzzer_next           = BZ_DISABLED;
              end
            end else if (stored_gear_next == GEAR_D) begin
              if (spd_zero) begin
                countdown_next        = off_wait_ticks;
                countdown_active_next = 1'b1;
              end
            end
          end
          EV_EXPIRY: begin
            cmd         = CMD_OFF;
            buzzer_next = BZ_DISABLED;
          end
          default: begin
          end
        endcase
      end
      BZ_DISABLED: begin
        case (ev)
          EV_SPEED: begin
            if (stored_gear_next != GEAR_P && spd_mid) begin
              cmd         = CMD_ON;
              buzzer_next = BZ_ENABLED;
            end
          end
          EV_GEAR: begin
            if (stored_gear_next == GEAR_R) begin
              cmd         = CMD_ON;
              buzzer_next = BZ_ENABLED;
            end else if (stored_gear_next == GEAR_N) begin
              if (spd_mid) begin
                cmd         = CMD_ON;
                buzzer_next = BZ_ENABLED;
              end
            end else if (stored_gear_next == GEAR_D) begin
              // Standstill in drive re-arms the buzzer with the off-wait timer.
              if (spd_zero) begin
                cmd                   = CMD_ON;
                countdown_next        = off_wait_ticks;
                countdown_active_next = 1'b1;
                buzzer_next           = BZ_ENABLED;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        buzzer_next = BZ_ENABLED;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_off_speed <= SWITCH_OFF_SPEED_RST;
      off_wait_ticks   <= OFF_WAIT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SWITCH_OFF_SPEED: switch_off_speed <= cfg_data[SpeedW-1:0];
        CFG_OFF_WAIT_TICKS:   off_wait_ticks   <= cfg_data[WaitW-1:0];
        default: begin
        end
      endcase
    end
  end

  // State update on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      buzzer           <= BZ_ENABLED;
      stored_speed     <= '0;
      speed_known      <= 1'b0;
      stored_gear      <= GEAR_NONE;
      countdown        <= '0;
      countdown_active <= 1'b0;
    end else if (accept) begin
      buzzer           <= buzzer_next;
      stored_speed     <= stored_speed_next;
      speed_known      <= speed_known_next;
      stored_gear      <= stored_gear_next;
      countdown        <= countdown_next;
      countdown_active <= countdown_active_next;
    end
  end

  // Result register: valid is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_enabled <= (buzzer_next == BZ_ENABLED);
      res_cmd     <= cmd;
      res_timer   <= countdown_active_next;
      res_speed   <= stored_speed_next;
      res_gear    <= stored_gear_next;
    end
  end

  assign out_ch.valid          = res_valid;
  assign out_ch.buzzer_enabled = res_enabled;
  assign out_ch.buzzer_cmd     = res_cmd;
  assign out_ch.timer_running  = res_timer;
  assign out_ch.speed_seen     = res_speed;
  assign out_ch.gear_seen      = res_gear;

endmodule

FILE: hw/rtl/pbgsc_checker.sv
// ---------------------------------------------------------------------------
// pbgsc_checker
// Port-level checks of the park buzzer controller, bound to the top level.
// ---------------------------------------------------------------------------
module pbgsc_checker import pbgsc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_enabled,
  input logic [CmdW-1:0]   out_cmd,
  input logic              out_timer,
  input logic [SpeedW-1:0] out_speed,
  input logic [GearW-1:0]  out_gear
);

  // A stalled result word holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd) &&
    $stable(out_enabled) && $stable(out_timer) && $stable(out_speed) &&
    $stable(out_gear))
    else $error("stalled result word changed");

  // An on command leaves the buzzer enabled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_cmd == CMD_ON |-> out_enabled)
    else $error("switch-on command with buzzer disabled");

  // An off command leaves the buzzer disabled with the timer stopped.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_cmd == CMD_OFF |-> !out_enabled && !out_timer)
    else $error("switch-off command with buzzer or timer still on");

  // The off-wait timer only runs while the buzzer is enabled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_timer |-> out_enabled)
    else $error("timer running with buzzer disabled");

  // Reset leaves no result word pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind park_buzzer_gear_speed_controller pbgsc_checker u_pbgsc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_enabled (out_ch.buzzer_enabled),
  .out_cmd     (out_ch.buzzer_cmd),
  .out_timer   (out_ch.timer_running),
  .out_speed   (out_ch.speed_seen),
  .out_gear    (out_ch.gear_seen)
);

FILE: tb/sv/pbgsc_checker.sv
// ---------------------------------------------------------------------------
// pbgsc_scoreboard
// Passive scoreboard for the park buzzer controller. It follows register
// writes and accepted input words, predicts each result word from its own
// copy of the buzzer state, and compares every accepted result with the
// oldest prediction.
// ---------------------------------------------------------------------------
module pbgsc_scoreboard import pbgsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  pbgsc_in_if                 in_ch,
  pbgsc_out_if                out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  n_fail,
  output int                  n_pending,
  output int                  n_checked,
  output int                  n_cmd_on,
  output int                  n_cmd_off
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              buzzer_enabled;
    logic [CmdW-1:0]   buzzer_cmd;
    logic              timer_running;
    logic [SpeedW-1:0] speed_seen;
    logic [GearW-1:0]  gear_seen;
  } status_t;

  // Register copies.
  logic [SpeedW-1:0] off_limit;
  logic [WaitW-1:0]  wait_load;

  // Controller state as predicted.
  logic              buzz_on;
  logic [SpeedW-1:0] speed_val;
  logic              speed_known;
  logic [GearW-1:0]  gear_val;
  logic [WaitW-1:0]  cd_count;
  logic              cd_run;

  status_t status_q[$];

  // Speed tests are all false until a speed frame has been stored.
  function automatic logic at_standstill();
    return speed_known && speed_val == '0;
  endfunction

  function automatic logic above_limit();
    return speed_known && speed_val >= off_limit;
  endfunction

  function automatic logic below_limit();
    return speed_known && speed_val != '0 && speed_val < off_limit;
  endfunction

  function automatic void start_wait();
    cd_count = wait_load;
    cd_run   = 1'b1;
  endfunction

  function automatic logic [CmdW-1:0] buzzer_react(event_t ev);
    logic [CmdW-1:0] cmd;
    cmd = CMD_NONE;
    if (buzz_on) begin
      if (ev == EV_SPEED) begin
        if (gear_val != GEAR_R) begin
          if (at_standstill()) begin
            start_wait();
          end else begin
            cd_run = 1'b0;
            if (above_limit()) begin
              cmd = CMD_OFF;
              buzz_on = 1'b0;
            end
          end
        end
      end else if (ev == EV_GEAR) begin
        if (gear_val == GEAR_P) begin
          cmd = CMD_OFF;
          cd_run = 1'b0;
          buzz_on = 1'b0;
        end else if (gear_val == GEAR_R) begin
          cd_run = 1'b0;
        end else if (gear_val == GEAR_N) begin
          if (at_standstill() || above_limit()) begin
            cmd = CMD_OFF;
            cd_run = 1'b0;
            buzz_on = 1'b0;
          end
        end else if (gear_val == GEAR_D) begin
          if (at_standstill()) start_wait();
        end
      end else begin
        cmd = CMD_OFF;
        buzz_on = 1'b0;
      end
    end else begin
      if (ev == EV_SPEED) begin
        if (gear_val != GEAR_P && below_limit()) begin
          cmd = CMD_ON;
          buzz_on = 1'b1;
        end
      end else if (ev == EV_GEAR) begin
        if (gear_val == GEAR_R) begin
          cmd = CMD_ON;
          buzz_on = 1'b1;
        end else if (gear_val == GEAR_N) begin
          if (below_limit()) begin
            cmd = CMD_ON;
            buzz_on = 1'b1;
          end
        end else if (gear_val == GEAR_D) begin
          if (at_standstill()) begin
            cmd = CMD_ON;
            start_wait();
            buzz_on = 1'b1;
          end
        end
      end
    end
    return cmd;
  endfunction

  function automatic status_t predict_status(logic op, logic [1:0] kind, logic [7:0] b0,
                                             logic [7:0] b1);
    logic [CmdW-1:0]   cmd;
    logic [SpeedW-1:0] spd;
    logic [GearW-1:0]  g;
    status_t           r;
    cmd = CMD_NONE;
    if (op == OP_TICK) begin
      if (cd_run) begin
        // A load of zero expires on the first tick, like a load of one.
        if (cd_count <= 1) begin
          cd_count = '0;
          cd_run = 1'b0;
          cmd = buzzer_react(EV_EXPIRY);
        end else begin
          cd_count = cd_count - 1'b1;
        end
      end
    end else if (kind == KIND_SPEED) begin
      spd = {b1[3:0] & MASK_NIBBLE[3:0], b0};
      if (!speed_known || spd != speed_val) begin
        speed_val = spd;
        speed_known = 1'b1;
        cmd = buzzer_react(EV_SPEED);
      end
    end else if (kind == KIND_GEAR) begin
      g = GEAR_NONE;
      if ((b0 & MASK_P) != 0) g = GEAR_P;
      else if ((b0 & MASK_R) != 0) g = GEAR_R;
      else if ((b0 & MASK_N) != 0) g = GEAR_N;
      else if ((b0 & MASK_D) != 0) g = GEAR_D;
      if (g != GEAR_NONE && g != gear_val) begin
        gear_val = g;
        cmd = buzzer_react(EV_GEAR);
      end
    end
    r.buzzer_enabled = buzz_on;
    r.buzzer_cmd     = cmd;
    r.timer_running  = cd_run;
    r.speed_seen     = speed_val;
    r.gear_seen      = gear_val;
    return r;
  endfunction

  initial begin
    n_fail    = 0;
    n_pending = 0;
    n_checked = 0;
    n_cmd_on  = 0;
    n_cmd_off = 0;
  end

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst) begin
      off_limit   = SWITCH_OFF_SPEED_RST;
      wait_load   = OFF_WAIT_TICKS_RST;
      buzz_on     = 1'b1;
      speed_val   = '0;
      speed_known = 1'b0;
      gear_val    = GEAR_NONE;
      cd_count    = '0;
      cd_run      = 1'b0;
      status_q.delete();
    end else begin
      // The result leaving at this edge belongs to an earlier input word.
      if (out_ch.valid && out_ch.ready) begin
        got.buzzer_enabled = out_ch.buzzer_enabled;
        got.buzzer_cmd     = out_ch.buzzer_cmd;
        got.timer_running  = out_ch.timer_running;
        got.speed_seen     = out_ch.speed_seen;
        got.gear_seen      = out_ch.gear_seen;
        if (status_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display({"%0t: result word with no prediction waiting: ",
                      "en=%0d cmd=%0d run=%0d spd=%0d gear=%0d"},
                     $time, got.buzzer_enabled, got.buzzer_cmd, got.timer_running,
                     got.speed_seen, got.gear_seen);
        end else begin
          want = status_q.pop_front();
          n_checked++;
          if (want.buzzer_cmd == CMD_ON) n_cmd_on++;
          if (want.buzzer_cmd == CMD_OFF) n_cmd_off++;
          if (got.buzzer_enabled !== want.buzzer_enabled ||
              got.buzzer_cmd     !== want.buzzer_cmd     ||
              got.timer_running  !== want.timer_running  ||
              got.speed_seen     !== want.speed_seen     ||
              got.gear_seen      !== want.gear_seen) begin
            n_fail++;
            if (n_fail <= 10)
              $display({"%0t: result %0d expected en=%0d cmd=%0d run=%0d spd=%0d ",
                        "gear=%0d, got en=%0d cmd=%0d run=%0d spd=%0d gear=%0d"},
                       $time, n_checked, want.buzzer_enabled, want.buzzer_cmd,
                       want.timer_running, want.speed_seen, want.gear_seen,
                       got.buzzer_enabled, got.buzzer_cmd, got.timer_running,
                       got.speed_seen, got.gear_seen);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_SWITCH_OFF_SPEED) off_limit = cfg_data[SpeedW-1:0];
        else if (cfg_index == CFG_OFF_WAIT_TICKS) wait_load = cfg_data[WaitW-1:0];
      end
      if (in_ch.valid && in_ch.ready)
        status_q.push_back(predict_status(in_ch.op, in_ch.frame_kind, in_ch.byte0,
                                          in_ch.byte1));
    end
    n_pending = status_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Top of the park buzzer controller testbench. It drives bus frames and
// ticks through a short directed sequence and then through several register
// settings with random content, throttles both channels, and reports the
// verdict that the scoreboard collects.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbgsc_pkg::*;

  // Frame kinds 2 and 3 carry other traffic that the controller ignores.
  localparam logic [1:0] KIND_OTHER = 2'd2;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  pbgsc_in_if  in_ch();
  pbgsc_out_if out_ch();

  int n_fail;
  int n_pending;
  int n_checked;
  int n_cmd_on;
  int n_cmd_off;

  int n_sent;
  int n_recv;
  int n_settings;

  // When set, neither side inserts gaps, so that stretches of full-rate
  // traffic are exercised as well.
  bit quiet;

  // Speed most recently sent, so that unchanged speeds can be repeated.
  logic [SpeedW-1:0] last_speed;

  park_buzzer_gear_speed_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pbgsc_scoreboard u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked),
    .n_cmd_on  (n_cmd_on),
    .n_cmd_off (n_cmd_off)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap length for either side: mostly none or short, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result words are counted here only to know when the block has drained.
  always @(posedge clk) begin
    if (rst) begin
      n_recv <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      n_recv <= n_recv + 1;
    end
  end

  // The result side stalls in random bursts for the whole run.
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Offers one input word and returns at the edge that accepts it. Valid
  // stays high across back-to-back words and is lowered only for a gap.
  task automatic send_word(logic op, logic [1:0] kind, logic [7:0] b0, logic [7:0] b1);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.frame_kind <= kind;
    in_ch.byte0      <= b0;
    in_ch.byte1      <= b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    n_sent++;
  endtask

  // Every input word produces exactly one result, so the block is idle once
  // the counts agree.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (n_recv != n_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Speeds cluster around the interesting points: standstill, just below,
  // at and just above the switch-off limit, and repeats of the last value.
  function automatic logic [SpeedW-1:0] pick_speed(logic [SpeedW-1:0] lim);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 30) return last_speed;
    if (r < 55) return (lim > 1) ? SpeedW'($urandom_range(1, lim - 1)) : SpeedW'(1);
    if (r < 75) begin
      v = int'(lim) + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return SpeedW'(v);
    end
    if (r < 90) return SpeedW'($urandom_range(lim, 4095));
    return SpeedW'($urandom_range(0, 4095));
  endfunction

  task automatic random_word(logic [SpeedW-1:0] lim);
    int               r;
    int               g;
    logic [SpeedW-1:0] spd;
    logic [3:0]        nib;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // Ticks carry junk in the frame fields, which must not matter.
      send_word(OP_TICK, 2'($urandom), 8'($urandom), 8'($urandom));
    end else if (r < 65) begin
      spd = pick_speed(lim);
      last_speed = spd;
      send_word(OP_FRAME, KIND_SPEED, spd[7:0], {4'($urandom), spd[11:8]});
    end else if (r < 90) begin
      // Mostly one gear bit; sometimes several (lowest wins) or none.
      g = $urandom_range(0, 9);
      if (g < 7) nib = 4'(1 << $urandom_range(0, 3));
      else if (g < 9) nib = 4'($urandom_range(1, 15));
      else nib = 4'h0;
      send_word(OP_FRAME, KIND_GEAR, {4'($urandom), nib}, 8'($urandom));
    end else begin
      send_word(OP_FRAME, KIND_OTHER | 2'($urandom_range(0, 1)), 8'($urandom),
                8'($urandom));
    end
  endtask

  // One register setting followed by a stretch of random traffic. The speed
  // register gets junk in its unused upper bits.
  task automatic run_setting(logic [SpeedW-1:0] lim, logic [WaitW-1:0] wait_ticks,
                             bit calm, int count);
    drain();
    write_reg(CFG_SWITCH_OFF_SPEED, {4'($urandom), lim});
    write_reg(CFG_OFF_WAIT_TICKS, wait_ticks);
    quiet = calm;
    n_settings++;
    repeat (count) random_word(lim);
  endtask

  initial begin
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_FRAME;
    in_ch.frame_kind <= KIND_SPEED;
    in_ch.byte0      <= '0;
    in_ch.byte1      <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_SWITCH_OFF_SPEED;
    cfg_data         <= '0;
    quiet            = 1'b0;
    last_speed       = '0;
    n_sent           = 0;
    n_settings       = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sequence with a limit of 100 and a two-tick off wait.
    write_reg(CFG_SWITCH_OFF_SPEED, 16'd100);
    write_reg(CFG_OFF_WAIT_TICKS, 16'd2);
    n_settings++;
    // A tick with the countdown stopped, a gear frame with no gear bits and
    // both kinds of foreign frame must all leave the state alone.
    send_word(OP_TICK, 2'($urandom), 8'hFF, 8'hFF);
    send_word(OP_FRAME, KIND_GEAR, 8'hF0, 8'hFF);
    send_word(OP_FRAME, KIND_OTHER, 8'hFF, 8'hFF);
    send_word(OP_FRAME, KIND_OTHER | 2'd1, 8'h00, 8'h00);
    // Gears while the speed is still unknown: no speed test may pass.
    send_word(OP_FRAME, KIND_GEAR, MASK_D, 8'h00);
    send_word(OP_FRAME, KIND_GEAR, MASK_N, 8'h00);
    // First speed frame is zero, with junk above the speed nibble; in N this
    // starts the countdown, which then runs out on the second tick.
    send_word(OP_FRAME, KIND_SPEED, 8'h00, 8'hF0);
    send_word(OP_TICK, KIND_SPEED, 8'h00, 8'h00);
    send_word(OP_TICK, KIND_GEAR, 8'h00, 8'h00);
    // Same speed again raises no event.
    send_word(OP_FRAME, KIND_SPEED, 8'h00, 8'h00);
    // D at standstill switches on and restarts the countdown; R stops it.
    send_word(OP_FRAME, KIND_GEAR, MASK_D, 8'h00);
    send_word(OP_FRAME, KIND_GEAR, MASK_R, 8'hFF);
    // Top speed is ignored in reverse.
    send_word(OP_FRAME, KIND_SPEED, 8'hFF, 8'h0F);
    // All gear bits set: park wins and switches off.
    send_word(OP_FRAME, KIND_GEAR, 8'hFF, 8'h00);
    send_word(OP_FRAME, KIND_SPEED, 8'd50, 8'h00);
    // N and D bits together select N; the speed is in range, so on again.
    send_word(OP_FRAME, KIND_GEAR, MASK_N | MASK_D, 8'h00);
    send_word(OP_FRAME, KIND_SPEED, 8'd100, 8'h00);
    send_word(OP_FRAME, KIND_SPEED, 8'd99, 8'h00);
    send_word(OP_FRAME, KIND_SPEED, 8'd0, 8'h00);
    send_word(OP_FRAME, KIND_GEAR, MASK_D, 8'h00);
    send_word(OP_TICK, KIND_SPEED, 8'h00, 8'h00);
    send_word(OP_TICK, KIND_SPEED, 8'h00, 8'h00);
    // Tick in the disabled state with the countdown stopped.
    send_word(OP_TICK, KIND_SPEED, 8'h00, 8'h00);
    send_word(OP_FRAME, KIND_GEAR, MASK_R, 8'h00);

    // Random traffic over a spread of settings, extremes included. A wait
    // of zero must behave like a wait of one.
    run_setting(12'd100, 16'd3, 1'b0, 190);
    run_setting(12'd0, 16'd0, 1'b0, 190);
    run_setting(12'd4095, 16'd65535, 1'b1, 190);
    run_setting(12'd1, 16'd1, 1'b0, 190);
    run_setting(12'd50, 16'd8, 1'b1, 190);
    run_setting(12'($urandom_range(2, 300)), 16'($urandom_range(1, 20)), 1'b0, 190);
    run_setting(12'($urandom_range(2, 300)), 16'($urandom_range(1, 20)), 1'b0, 190);
    run_setting(12'($urandom_range(301, 4094)), 16'($urandom_range(1, 20)), 1'b0, 190);
    run_setting(12'd4095, 16'd5, 1'b0, 190);
    run_setting(SWITCH_OFF_SPEED_RST, 16'd2, 1'b0, 190);
    drain();

    $display("%0d input words under %0d register settings; %0d results compared",
             n_sent, n_settings, n_checked);
    $display("buzzer switched on %0d times and off %0d times", n_cmd_on, n_cmd_off);
    if (n_fail == 0 && n_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (n_pending != 0) $display("%0d predicted results never arrived", n_pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("timeout with %0d words sent and %0d results received", n_sent, n_recv);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/pbgsc_pkg.sv
hw/rtl/pbgsc_if.sv
hw/rtl/park_buzzer_gear_speed_controller.sv
hw/rtl/pbgsc_checker.sv
tb/sv/pbgsc_checker.sv
tb/sv/tb.sv
